// ===== sv/ffva_pkg.sv =====
// Shared types and constants of the first-fit video memory allocator.
// Used by the controller, the top level and the checker; depends on nothing.
package ffva_pkg;

  localparam int MAX_CHUNKS = 32;
  localparam int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int ADDR_W     = 32;
  localparam int ENT_W      = 2 * ADDR_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHUNKS);

  localparam logic [ADDR_W:0] ALIGN_STEP = (ADDR_W + 1)'(16);
  localparam logic [3:0]      ALIGN_MASK = 4'hF;
  localparam logic [ADDR_W:0] LIMIT_CAP  = {1'b1, {ADDR_W{1'b0}}};

  localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h0400_0000;
  localparam logic [ADDR_W-1:0] REGION_SIZE_RST = 32'h0020_0000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOSPACE  = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== sv/ffva_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module ffva_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ffva_ctrl.sv =====
// Sequencer of the allocator: scans the chunk table in memory, shifts entries
// to insert or remove one, and produces one result per item. Uses ffva_pkg.
module ffva_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [31:0]              in_request_size,
  input  logic [31:0]              in_free_address,
  input  logic [ffva_pkg::ADDR_W-1:0] region_base,
  input  logic [ffva_pkg::ADDR_W-1:0] region_size,
  output ffva_pkg::ram_req_t       ram_req,
  input  logic [ffva_pkg::ENT_W-1:0] ram_rdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output ffva_pkg::result_t        res
);
  import ffva_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_FIT  = 7'b0001000,
    S_SHRD = 7'b0010000,
    S_SHWR = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              kind_r, kind_nxt;
  logic [ADDR_W:0]   size_r, size_nxt;
  logic [ADDR_W-1:0] key_r, key_nxt;
  logic [ADDR_W:0]   run_r, run_nxt;
  logic [ADDR_W:0]   limit_r, limit_nxt;
  result_t           res_r, res_nxt;

  logic [ADDR_W:0]   ent_start;
  logic [ADDR_W:0]   ent_len;
  logic [ADDR_W:0]   cfg_sum;
  logic [ADDR_W:0]   rounded;
  logic [ADDR_W+1:0] append_end;
  logic              gap_fits;
  logic [CNT_W-1:0]  k_inc;
  logic [CNT_W-1:0]  k_dec;

  assign ent_start  = {1'b0, ram_rdata[ENT_W-1:ADDR_W]};
  assign ent_len    = {1'b0, ram_rdata[ADDR_W-1:0]};
  assign cfg_sum    = {1'b0, region_base} + {1'b0, region_size};
  assign rounded    = (in_request_size[3:0] & ALIGN_MASK) != 4'd0
                    ? {1'b0, in_request_size[31:4], 4'd0} + ALIGN_STEP
                    : {1'b0, in_request_size};
  assign append_end = {1'b0, run_r} + {1'b0, size_r};
  // An entry that starts below the running end leaves no gap at all.
  assign gap_fits   = (ent_start >= run_r) && (size_r <= ent_start - run_r);
  assign k_inc      = k_r + 1'b1;
  assign k_dec      = k_r - 1'b1;

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    kind_nxt  = kind_r;
    size_nxt  = size_r;
    key_nxt   = key_r;
    run_nxt   = run_r;
    limit_nxt = limit_r;
    res_nxt   = res_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = k_r[IDX_W-1:0];
    ram_req.wdata = {run_r[ADDR_W-1:0], size_r[ADDR_W-1:0]};
    ram_req.raddr = k_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          size_nxt  = rounded;
          key_nxt   = in_free_address;
          run_nxt   = {1'b0, region_base};
          limit_nxt = (cfg_sum > LIMIT_CAP) ? LIMIT_CAP : cfg_sum;
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (k_r == count_r) begin
          if (kind_r == KIND_ALLOC) begin
            pos_nxt   = count_r;
            state_nxt = S_FIT;
          end else begin
            res_nxt   = '{addr: '0, status: ST_NOTFOUND};
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (kind_r == KIND_ALLOC) begin
          if (gap_fits) begin
            pos_nxt   = k_r;
            state_nxt = S_FIT;
          end else begin
            run_nxt   = ent_start + ent_len;
            k_nxt     = k_inc;
            state_nxt = S_RD;
          end
        end else if (ent_start[ADDR_W-1:0] == key_r) begin
          pos_nxt   = k_r;
          state_nxt = S_SHRD;
        end else begin
          k_nxt     = k_inc;
          state_nxt = S_RD;
        end
      end
      S_FIT: begin
        // The region end only limits an append, and it is checked before fullness.
        if (pos_r == count_r && (append_end > {1'b0, limit_r} || run_r[ADDR_W])) begin
          res_nxt   = '{addr: '0, status: ST_NOSPACE};
          state_nxt = S_DONE;
        end else if (count_r == CNT_MAX) begin
          res_nxt   = '{addr: '0, status: ST_FULL};
          state_nxt = S_DONE;
        end else begin
          k_nxt     = count_r;
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        if (kind_r == KIND_ALLOC) begin
          if (k_r == pos_r) begin
            ram_req.we = 1'b1;
            count_nxt  = count_r + 1'b1;
            res_nxt    = '{addr: run_r[ADDR_W-1:0], status: ST_OK};
            state_nxt  = S_DONE;
          end else begin
            ram_req.raddr = k_dec[IDX_W-1:0];
            state_nxt     = S_SHWR;
          end
        end else begin
          if (k_inc >= count_r) begin
            count_nxt = count_r - 1'b1;
            res_nxt   = '{addr: '0, status: ST_OK};
            state_nxt = S_DONE;
          end else begin
            ram_req.raddr = k_inc[IDX_W-1:0];
            state_nxt     = S_SHWR;
          end
        end
      end
      S_SHWR: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = ram_rdata;
        k_nxt         = (kind_r == KIND_ALLOC) ? k_dec : k_inc;
        state_nxt     = S_SHRD;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    pos_r   <= pos_nxt;
    kind_r  <= kind_nxt;
    size_r  <= size_nxt;
    key_r   <= key_nxt;
    run_r   <= run_nxt;
    limit_r <= limit_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ===== sv/first_fit_vram_allocator.sv =====
// Top level of the first-fit video memory allocator: region registers,
// result register, chunk table memory and sequencer. Uses ffva_pkg.
//
// Usage: an item on the in_ channel either allocates (in_kind 0) a chunk of
// in_request_size bytes, rounded up to 16, or frees (in_kind 1) the chunk
// that starts at in_free_address. Each item yields exactly one result on the
// out_ channel: the granted start address and a status code.
// The chunk table lives in one memory with a registered read, so each entry
// visited takes a read state and a check state; items are handled one at a
// time and in_stall stays high meanwhile.
// The result waits in an output register; the next item is accepted while
// the receiver stalls it, and its result is held back until the register
// is taken.
// Reset (synchronous, rst_n low) empties the table and restores the region
// registers; no clearing pass is needed. Write cfg_ only while idle.
module first_fit_vram_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [31:0]                      in_request_size,
  input  logic [31:0]                      in_free_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      out_chunk_address,
  output logic [1:0]                       out_status,
  input  logic                             cfg_we,
  input  logic [ffva_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import ffva_pkg::*;

  logic [ADDR_W-1:0] region_base_r;
  logic [ADDR_W-1:0] region_size_r;
  logic              out_valid_r;
  result_t           out_res_r;
  ram_req_t          ram_req;
  logic [ENT_W-1:0]  ram_rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= REGION_BASE_RST;
      region_size_r <= REGION_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_BASE: region_base_r <= cfg_data;
        CFG_REGION_SIZE: region_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chunk_address = out_res_r.addr;
  assign out_status        = out_res_r.status;

  ffva_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_CHUNKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  ffva_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_request_size(in_request_size),
    .in_free_address(in_free_address),
    .region_base    (region_base_r),
    .region_size    (region_size_r),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

endmodule

// ===== sv/ffva_checker.sv =====
// Port-level checker for the allocator, bound to the top level below.
// Uses ffva_pkg for the status codes.
module ffva_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [31:0]                    out_chunk_address,
  input logic [1:0]                     out_status
);
  import ffva_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chunk_address)
      && $stable(out_status))
    else $error("stalled result changed");

  // Only a granted allocation carries an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_chunk_address == '0)
    else $error("failed item carries an address");

  // Items are handled one at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // The result never appears in the cycle right after acceptance.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind first_fit_vram_allocator ffva_checker u_ffva_checker (.*);
